>>> rtl/core/avat_pkg.sv
// ----------------------------------------------------------------------------
// avat_pkg: shared types and constants of the vector angle block
// Tangent table, ratio and angle constants, status structs, FSM codes.
// ----------------------------------------------------------------------------
package avat_pkg;

    // quotient bits produced by the serial divider (ratio is always below 128)
    localparam int DIV_STEPS = 7;

    localparam logic [6:0] Q_FULL    = 7'd127;
    localparam logic [6:0] ANG_RIGHT = 7'd64;
    localparam logic [7:0] ANG_HALF  = 8'h80;

    // tan(k * 45deg / 32) * 127 for k = 1..31, last entry stands for 45 degrees
    localparam logic [6:0] TAN_ROM [32] = '{
        7'd3,   7'd6,   7'd9,   7'd13,  7'd16,  7'd19,  7'd22,  7'd25,
        7'd29,  7'd32,  7'd35,  7'd39,  7'd42,  7'd45,  7'd49,  7'd53,
        7'd56,  7'd60,  7'd64,  7'd68,  7'd72,  7'd76,  7'd80,  7'd85,
        7'd89,  7'd94,  7'd99,  7'd104, 7'd110, 7'd115, 7'd121, 7'd127
    };

    typedef struct packed {
        logic       done;
        logic [6:0] q;
    } t_div_stat;

    typedef struct packed {
        logic       done;
        logic [5:0] oct;
    } t_srch_stat;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SRCH = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    // magnitude of a signed byte, -128 saturates to 127
    function automatic logic [6:0] avat_mag(input logic [7:0] v);
        logic [7:0] neg;
        neg = 8'd0 - v;
        if (!v[7]) begin
            return v[6:0];
        end
        if (neg[7]) begin
            return Q_FULL;
        end
        return neg[6:0];
    endfunction

endpackage

>>> rtl/core/avat_in_if.sv
// ----------------------------------------------------------------------------
// avat_in_if: input vector channel
// Valid/ready handshake carrying one (x, y) vector per item.
// ----------------------------------------------------------------------------
interface avat_in_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] vec_x;
    logic signed [7:0] vec_y;

    modport source (output valid, output vec_x, output vec_y, input ready);
    modport sink   (input valid, input vec_x, input vec_y, output ready);
endinterface

>>> rtl/core/avat_out_if.sv
// ----------------------------------------------------------------------------
// avat_out_if: output angle channel
// Valid/ready handshake carrying one angle and its error flag per item.
// ----------------------------------------------------------------------------
interface avat_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] angle;
    logic              angle_error;

    modport source (output valid, output angle, output angle_error, input ready);
    modport sink   (input valid, input angle, input angle_error, output ready);
endinterface

>>> rtl/core/vector_angle_atan2.sv
// ----------------------------------------------------------------------------
// vector_angle_atan2: angle of a signed 8-bit vector
// Input channel takes (vec_x, vec_y); output channel gives angle and
// angle_error, with 64 standing for 90 degrees and -128 flagging a half turn.
//
// One item is worked on at a time. After acceptance the ratio of the smaller
// magnitude over the larger is formed by a bit-serial divider, then the
// tangent table is walked one entry per cycle, for longer at angles nearer
// 45 degrees; the quadrant is then fixed, the result is registered inside
// the block and is handed on to the output register once that is free.
// The next item is accepted once the block is idle again after hand-over;
// the divider and the table walk set most of the spacing between items.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, a finished second result holds inside the
// block and no further item is accepted until the output register frees.
// Reset empties the block; no state carries from one item to the next.
// ----------------------------------------------------------------------------
module vector_angle_atan2 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    avat_in_if.sink     i_in,
    avat_out_if.source  o_out
);
    import avat_pkg::*;

    t_state     r_state;
    logic       r_swap;
    logic       r_xneg;
    logic       r_yneg;
    logic       r_res_err;
    logic [7:0] r_res_ang;
    logic       r_out_valid;
    logic       r_out_err;
    logic [7:0] r_out_ang;

    logic       w_in_acc;
    logic [6:0] w_ax;
    logic [6:0] w_ay;
    logic       w_swap;
    logic [6:0] w_num;
    logic [6:0] w_den;
    logic [6:0] w_fi;
    logic [7:0] w_fi8;
    logic [7:0] w_ang;
    logic       w_err;
    logic       w_out_free;
    logic       w_hand;

    t_div_stat  w_div;
    t_srch_stat w_srch;

    assign w_in_acc = i_in.valid && i_in.ready;
    assign w_ax     = avat_mag(i_in.vec_x);
    assign w_ay     = avat_mag(i_in.vec_y);
    assign w_swap   = w_ay > w_ax;
    assign w_num    = w_swap ? w_ax : w_ay;
    assign w_den    = w_swap ? w_ay : w_ax;

    avat_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_acc),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_stat  (w_div)
    );

    avat_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div.done),
        .i_q     (w_div.q),
        .o_stat  (w_srch)
    );

    // mirror about 45 degrees, then fix the quadrant
    assign w_fi  = r_swap ? (ANG_RIGHT - {1'b0, w_srch.oct}) : {1'b0, w_srch.oct};
    assign w_fi8 = {1'b0, w_fi};
    assign w_err = r_xneg && (w_fi == 7'd0);

    always_comb begin
        if (w_err) begin
            w_ang = ANG_HALF;
        end else if (!r_xneg) begin
            w_ang = r_yneg ? (8'd0 - w_fi8) : w_fi8;
        end else begin
            w_ang = r_yneg ? (w_fi8 + ANG_HALF) : (ANG_HALF - w_fi8);
        end
    end

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_hand     = (r_state == S_HOLD) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_swap  <= w_swap;
                        r_xneg  <= i_in.vec_x[7];
                        r_yneg  <= i_in.vec_y[7];
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (w_srch.done) begin
                        r_res_ang <= w_ang;
                        r_res_err <= w_err;
                        r_state   <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    // hand over once the output register is free
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_hand) begin
            r_out_valid <= 1'b1;
            r_out_ang   <= r_res_ang;
            r_out_err   <= r_res_err;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.angle       = $signed(r_out_ang);
    assign o_out.angle_error = r_out_err;

    a_acc_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_DIV))
        else $error("accepted item did not start the divider phase");

    a_div_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_DIV))
        else $error("divider finished outside its phase");

    a_srch_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_srch.done |-> (r_state == S_SRCH))
        else $error("table search finished outside its phase");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.angle_error) |-> (r_out_ang == ANG_HALF))
        else $error("half-turn flag without the error angle");

    a_oct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_srch.done |-> (w_srch.oct <= 6'd32))
        else $error("octant angle beyond 45 degrees");

endmodule

>>> rtl/core/avat_div.sv
// ----------------------------------------------------------------------------
// avat_div: bit-serial ratio unit
// Forms round(127 * num / den) one quotient bit per cycle, restoring style.
// ----------------------------------------------------------------------------
module avat_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [6:0]           i_num,
    input  logic [6:0]           i_den,
    output avat_pkg::t_div_stat  o_stat
);
    import avat_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic        r_zero;
    logic        r_full;
    logic [2:0]  r_cnt;
    logic [6:0]  r_rem;
    logic [6:0]  r_dvd;
    logic [6:0]  r_quo;
    logic [6:0]  r_den;

    logic [13:0] w_prod;
    logic [7:0]  w_trial;
    logic        w_fit;
    logic [6:0]  w_round;

    assign w_prod  = {i_num, 7'b0} - {7'b0, i_num};
    assign w_trial = {r_rem, r_dvd[6]};
    assign w_fit   = w_trial >= {1'b0, r_den};
    // round up when the remainder passes half the divisor
    assign w_round = r_quo + {6'b0, (r_rem > (r_den >> 1))};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == 3'(DIV_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                // high half is already below den since the ratio stays under 128
                r_rem  <= w_prod[13:7];
                r_dvd  <= w_prod[6:0];
                r_quo  <= '0;
                r_den  <= i_den;
                r_zero <= (i_num == 7'd0);
                r_full <= (i_num == i_den);
            end else if (r_busy) begin
                r_dvd <= {r_dvd[5:0], 1'b0};
                r_quo <= {r_quo[5:0], w_fit};
                r_rem <= w_fit ? 7'(w_trial - {1'b0, r_den}) : w_trial[6:0];
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.q    = r_zero ? 7'd0 : (r_full ? Q_FULL : w_round);

endmodule

>>> rtl/core/avat_search.sv
// ----------------------------------------------------------------------------
// avat_search: serial tangent table search
// Walks the tangent table one entry per cycle, then rounds to the octant angle.
// ----------------------------------------------------------------------------
module avat_search (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [6:0]           i_q,
    output avat_pkg::t_srch_stat o_stat
);
    import avat_pkg::*;

    logic       r_busy;
    logic       r_done;
    logic [4:0] r_idx;
    logic [6:0] r_q;
    logic [6:0] r_prev;
    logic [5:0] r_oct;

    logic [6:0] w_cur;
    logic [6:0] w_diff;
    logic [6:0] w_half;
    logic       w_low;
    logic [5:0] w_idx;
    logic [5:0] w_oct;

    assign w_cur  = TAN_ROM[r_idx];
    assign w_diff = w_cur - r_prev;
    assign w_half = r_prev + (w_diff >> 1);
    assign w_low  = (r_q < w_half) || ((r_q == w_half) && w_diff[0]);
    assign w_idx  = {1'b0, r_idx};

    always_comb begin
        if (w_cur == r_q) begin
            w_oct = w_idx + 6'd1;
        end else if (w_low) begin
            w_oct = w_idx;
        end else begin
            w_oct = w_idx + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (w_cur >= r_q);
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_prev <= '0;
                r_q    <= i_q;
            end else if (r_busy) begin
                // last entry is 127, so the walk always stops by then
                if (w_cur >= r_q) begin
                    r_busy <= 1'b0;
                    r_oct  <= w_oct;
                end else begin
                    r_prev <= w_cur;
                    r_idx  <= r_idx + 5'd1;
                end
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.oct  = r_oct;

endmodule
